// File: sv/ffra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the first-fit range allocator
// Table geometry, command and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int MAX_RANGES = 64;
    localparam int SIZE_BITS  = 32;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int ENT_W      = 2 * SIZE_BITS;

    localparam logic [SIZE_BITS-1:0] RESET_TOTAL = SIZE_BITS'(65536);

    typedef logic [SIZE_BITS-1:0] t_val;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [ENT_W-1:0]     t_ent;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_ZERO     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_DOUBLE   = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_FULL     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        RS_IDX   = 2'd0,
        RS_IDXP1 = 2'd1,
        RS_J     = 2'd2
    } t_rsel;

    typedef enum logic [3:0] {
        W_CLR  = 4'd0,
        W_ALC  = 4'd1,
        W_EXT  = 4'd2,
        W_CUR  = 4'd3,
        W_CURM = 4'd4,
        W_NEWM = 4'd5,
        W_NEW  = 4'd6,
        W_APP  = 4'd7,
        W_SHD  = 4'd8,
        W_SHU  = 4'd9
    } t_wsel;

    typedef enum logic [2:0] {
        J_HOLD  = 3'd0,
        J_IDXP1 = 3'd1,
        J_IDXP2 = 3'd2,
        J_CNTM1 = 3'd3,
        J_INC   = 3'd4,
        J_DEC   = 3'd5
    } t_jop;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2,
        CNT_CLR  = 2'd3
    } t_cntop;

    typedef enum logic [1:0] {
        FT_HOLD = 2'd0,
        FT_ADD  = 2'd1,
        FT_SUB  = 2'd2,
        FT_CLR  = 2'd3
    } t_ftop;

    typedef struct packed {
        logic    ld;
        t_rsel   rd_sel;
        logic    we;
        t_wsel   wsel;
        logic    idx_inc;
        t_jop    jop;
        t_cntop  cntop;
        t_ftop   ftop;
        logic    cur_ld;
        logic    gr_ld;
        logic    st_ld;
        t_status st_code;
        logic    out_ld;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic size_zero;
        logic off_oor;
        logic cnt_zero;
        logic full;
        logic last;
        logic len_ge;
        logic len_eq;
        logic end_eq;
        logic st_eq;
        logic st_gt;
        logic end_lt;
        logic nxt_merge;
        logic new_merge;
        logic j_lt_cnt;
        logic p2_lt_cnt;
        logic j_eq_idx;
    } t_sts;

endpackage
`default_nettype wire

// File: sv/ffra_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_in_if: command channel
// Valid/ready channel carrying one allocator command item.
// ----------------------------------------------------------------------------
interface ffra_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [ffra_pkg::SIZE_BITS-1:0] size;
    logic [ffra_pkg::SIZE_BITS-1:0] offset;

    modport source (output valid, output command, output size, output offset, input ready);
    modport sink   (input valid, input command, input size, input offset, output ready);
endinterface
`default_nettype wire

// File: sv/ffra_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_out_if: result channel
// Valid/ready channel carrying one allocator result item.
// ----------------------------------------------------------------------------
interface ffra_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] alloc_offset;
    logic [31:0] free_units;

    modport source (output valid, output status, output alloc_offset, output free_units,
                    input ready);
    modport sink   (input valid, input status, input alloc_offset, input free_units,
                    output ready);
endinterface
`default_nettype wire

// File: sv/first_fit_range_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_range_allocator: first-fit free-list allocator with coalescing
//
// i_in carries one command item (allocate, free, clear, query) with size and
// offset; o_out returns exactly one result item per command: status, granted
// offset and the free total after the command. i_cfg_we/i_cfg_wdata load
// the space size; write it while idle and follow with a clear.
// Query and clear pass from a decode state to the finish state, which loads
// the result register. Allocate and free walk the 64-entry range RAM with a
// read state and an evaluate state per entry, then a remove or insert shifts
// the tail of the table with a read state and a write state per moved entry;
// the single-port-write RAM with registered read sets this pace. Commands are
// taken one at a time.
// Reset: the init state writes the single range (0, 65536) into entry zero,
// with i_in not ready in that state.
// A finished result sits in the output register while the next command is
// taken; if the receiver stalls, the following result waits until the
// register frees, and i_in stays not ready until then.
// ----------------------------------------------------------------------------
module first_fit_range_allocator (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [31:0]               i_cfg_wdata,
    ffra_in_if.sink                        i_in,
    ffra_out_if.source                     o_out
);

    ffra_pkg::t_ctl ctl;
    ffra_pkg::t_sts sts;

    ffra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    ffra_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_command      (i_in.command),
        .i_size         (i_in.size),
        .i_offset       (i_in.offset),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_status       (o_out.status),
        .o_alloc_offset (o_out.alloc_offset),
        .o_free_units   (o_out.free_units)
    );

endmodule
`default_nettype wire

// File: sv/ffra_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: sv/ffra_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_datapath: range table, counters and result registers
// Holds the free-range RAM, walk pointers, free total and compare flags.
// ----------------------------------------------------------------------------
module ffra_datapath (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire ffra_pkg::t_val          i_cfg_wdata,
    input  wire logic [1:0]              i_command,
    input  wire ffra_pkg::t_val          i_size,
    input  wire ffra_pkg::t_val          i_offset,
    input  wire ffra_pkg::t_ctl          i_ctl,
    output      ffra_pkg::t_sts          o_sts,
    output      logic [2:0]              o_status,
    output      ffra_pkg::t_val          o_alloc_offset,
    output      ffra_pkg::t_val          o_free_units
);

    ffra_pkg::t_val    r_total, r_size, r_off, r_ft, r_cur_s, r_cur_l, r_gr;
    ffra_pkg::t_cmd    r_cmd;
    ffra_pkg::t_cnt    r_cnt, r_j;
    ffra_pkg::t_idx    r_idx;
    ffra_pkg::t_status r_status;
    logic [2:0]        r_o_status;
    ffra_pkg::t_val    r_o_gr, r_o_fs;

    ffra_pkg::t_ent rdata, wdata;
    ffra_pkg::t_idx waddr, raddr;
    ffra_pkg::t_val rd_s, rd_l, rd_end;
    ffra_pkg::t_cnt idx_w, jm1, jp1;

    assign rd_s   = rdata[ffra_pkg::ENT_W-1:ffra_pkg::SIZE_BITS];
    assign rd_l   = rdata[ffra_pkg::SIZE_BITS-1:0];
    assign rd_end = rd_s + rd_l;
    assign idx_w  = ffra_pkg::CNT_W'(r_idx);
    assign jm1    = r_j - ffra_pkg::CNT_W'(1);
    assign jp1    = r_j + ffra_pkg::CNT_W'(1);

    always_comb begin
        unique case (i_ctl.rd_sel)
            ffra_pkg::RS_IDXP1: raddr = r_idx + ffra_pkg::IDX_W'(1);
            ffra_pkg::RS_J:     raddr = r_j[ffra_pkg::IDX_W-1:0];
            default:            raddr = r_idx;
        endcase
    end

    always_comb begin
        waddr = r_idx;
        wdata = {r_off, r_size};
        unique case (i_ctl.wsel)
            ffra_pkg::W_CLR: begin
                waddr = '0;
                wdata = {ffra_pkg::SIZE_BITS'(0), r_total};
            end
            ffra_pkg::W_ALC:  wdata = {rd_s + r_size, rd_l - r_size};
            ffra_pkg::W_EXT:  wdata = {rd_s, rd_l + r_size};
            ffra_pkg::W_CUR:  wdata = {r_cur_s, r_cur_l};
            ffra_pkg::W_CURM: wdata = {r_cur_s, r_cur_l + rd_l};
            ffra_pkg::W_NEWM: wdata = {r_off, r_size + rd_l};
            ffra_pkg::W_NEW:  wdata = {r_off, r_size};
            ffra_pkg::W_APP:  waddr = r_cnt[ffra_pkg::IDX_W-1:0];
            ffra_pkg::W_SHD: begin
                waddr = jm1[ffra_pkg::IDX_W-1:0];
                wdata = rdata;
            end
            ffra_pkg::W_SHU: begin
                waddr = jp1[ffra_pkg::IDX_W-1:0];
                wdata = rdata;
            end
            default: wdata = {r_off, r_size};
        endcase
    end

    ffra_ram #(
        .WIDTH (ffra_pkg::ENT_W),
        .DEPTH (ffra_pkg::MAX_RANGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.size_zero = (r_size == '0);
        o_sts.off_oor   = (r_off >= r_total);
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.full      = (r_cnt == ffra_pkg::CNT_W'(ffra_pkg::MAX_RANGES));
        o_sts.last      = ((idx_w + ffra_pkg::CNT_W'(1)) == r_cnt);
        o_sts.len_ge    = (rd_l >= r_size);
        o_sts.len_eq    = (rd_l == r_size);
        o_sts.end_eq    = (rd_end == r_off);
        o_sts.st_eq     = (rd_s == r_off);
        o_sts.st_gt     = (rd_s > r_off);
        o_sts.end_lt    = (rd_end < r_off);
        o_sts.nxt_merge = (rd_s == (r_cur_s + r_cur_l));
        o_sts.new_merge = ((r_off + r_size) == rd_s);
        o_sts.j_lt_cnt  = (r_j < r_cnt);
        o_sts.p2_lt_cnt = ((idx_w + ffra_pkg::CNT_W'(2)) < r_cnt);
        o_sts.j_eq_idx  = (r_j == idx_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= ffra_pkg::RESET_TOTAL;
            r_cnt   <= ffra_pkg::CNT_W'(1);
            r_ft    <= ffra_pkg::RESET_TOTAL;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            unique case (i_ctl.cntop)
                ffra_pkg::CNT_INC: r_cnt <= r_cnt + ffra_pkg::CNT_W'(1);
                ffra_pkg::CNT_DEC: r_cnt <= r_cnt - ffra_pkg::CNT_W'(1);
                ffra_pkg::CNT_CLR: r_cnt <= (r_total != '0) ? ffra_pkg::CNT_W'(1) : '0;
                default:           r_cnt <= r_cnt;
            endcase
            unique case (i_ctl.ftop)
                ffra_pkg::FT_ADD: r_ft <= r_ft + r_size;
                ffra_pkg::FT_SUB: r_ft <= r_ft - r_size;
                ffra_pkg::FT_CLR: r_ft <= r_total;
                default:          r_ft <= r_ft;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_cmd    <= ffra_pkg::t_cmd'(i_command);
            r_size   <= i_size;
            r_off    <= i_offset;
            r_idx    <= '0;
            r_gr     <= '0;
            r_status <= ffra_pkg::ST_OK;
        end else begin
            if (i_ctl.idx_inc) begin
                r_idx <= r_idx + ffra_pkg::IDX_W'(1);
            end
            if (i_ctl.gr_ld) begin
                r_gr <= rd_s;
            end
            if (i_ctl.st_ld) begin
                r_status <= i_ctl.st_code;
            end
        end
        if (i_ctl.cur_ld) begin
            r_cur_s <= rd_s;
            r_cur_l <= rd_l + r_size;
        end
        unique case (i_ctl.jop)
            ffra_pkg::J_IDXP1: r_j <= idx_w + ffra_pkg::CNT_W'(1);
            ffra_pkg::J_IDXP2: r_j <= idx_w + ffra_pkg::CNT_W'(2);
            ffra_pkg::J_CNTM1: r_j <= r_cnt - ffra_pkg::CNT_W'(1);
            ffra_pkg::J_INC:   r_j <= jp1;
            ffra_pkg::J_DEC:   r_j <= jm1;
            default:           r_j <= r_j;
        endcase
        if (i_ctl.out_ld) begin
            r_o_status <= r_status;
            r_o_gr     <= r_gr;
            r_o_fs     <= r_ft;
        end
    end

    assign o_status       = r_o_status;
    assign o_alloc_offset = r_o_gr;
    assign o_free_units   = r_o_fs;

endmodule
`default_nettype wire

// File: sv/ffra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_ctrl: command sequencer
// Walks the range table, drives shifts and merges, hands off results.
// ----------------------------------------------------------------------------
module ffra_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_ready,
    output      logic           o_out_valid,
    input  wire logic           i_out_ready,
    input  wire ffra_pkg::t_sts i_sts,
    output      ffra_pkg::t_ctl o_ctl
);

    typedef enum logic [12:0] {
        S_INIT = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_DEC  = 13'b0000000000100,
        S_RD   = 13'b0000000001000,
        S_EV   = 13'b0000000010000,
        S_NRD  = 13'b0000000100000,
        S_NEV  = 13'b0000001000000,
        S_SDR  = 13'b0000010000000,
        S_SDW  = 13'b0000100000000,
        S_SUR  = 13'b0001000000000,
        S_SUW  = 13'b0010000000000,
        S_INS  = 13'b0100000000000,
        S_FIN  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    ffra_pkg::t_ctl c;

    always_comb begin
        c          = '0;
        c.rd_sel   = ffra_pkg::RS_IDX;
        c.wsel     = ffra_pkg::W_NEW;
        c.jop      = ffra_pkg::J_HOLD;
        c.cntop    = ffra_pkg::CNT_HOLD;
        c.ftop     = ffra_pkg::FT_HOLD;
        c.st_code  = ffra_pkg::ST_OK;
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                c.we    = 1'b1;
                c.wsel  = ffra_pkg::W_CLR;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    c.ld    = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_sts.cmd)
                    ffra_pkg::CMD_ALLOC: begin
                        if (i_sts.cnt_zero) begin
                            c.st_ld   = 1'b1;
                            c.st_code = ffra_pkg::ST_NOFIT;
                            n_state   = S_FIN;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    ffra_pkg::CMD_FREE: begin
                        priority if (i_sts.size_zero) begin
                            c.st_ld   = 1'b1;
                            c.st_code = ffra_pkg::ST_ZERO;
                            n_state   = S_FIN;
                        end else if (i_sts.off_oor) begin
                            c.st_ld   = 1'b1;
                            c.st_code = ffra_pkg::ST_RANGE;
                            n_state   = S_FIN;
                        end else if (i_sts.cnt_zero) begin
                            c.we    = 1'b1;
                            c.wsel  = ffra_pkg::W_NEW;
                            c.cntop = ffra_pkg::CNT_INC;
                            c.ftop  = ffra_pkg::FT_ADD;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    ffra_pkg::CMD_CLEAR: begin
                        c.we    = 1'b1;
                        c.wsel  = ffra_pkg::W_CLR;
                        c.cntop = ffra_pkg::CNT_CLR;
                        c.ftop  = ffra_pkg::FT_CLR;
                        n_state = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (i_sts.cmd == ffra_pkg::CMD_ALLOC) begin
                    if (i_sts.len_ge) begin
                        c.gr_ld = 1'b1;
                        c.ftop  = ffra_pkg::FT_SUB;
                        if (i_sts.len_eq) begin
                            c.cntop = ffra_pkg::CNT_DEC;
                            if (i_sts.last) begin
                                n_state = S_FIN;
                            end else begin
                                c.jop   = ffra_pkg::J_IDXP1;
                                n_state = S_SDR;
                            end
                        end else begin
                            c.we    = 1'b1;
                            c.wsel  = ffra_pkg::W_ALC;
                            n_state = S_FIN;
                        end
                    end else if (i_sts.last) begin
                        c.st_ld   = 1'b1;
                        c.st_code = ffra_pkg::ST_NOFIT;
                        n_state   = S_FIN;
                    end else begin
                        c.idx_inc = 1'b1;
                        n_state   = S_RD;
                    end
                end else begin
                    priority if (i_sts.end_eq) begin
                        c.ftop = ffra_pkg::FT_ADD;
                        if (i_sts.last) begin
                            c.we    = 1'b1;
                            c.wsel  = ffra_pkg::W_EXT;
                            n_state = S_FIN;
                        end else begin
                            c.cur_ld = 1'b1;
                            n_state  = S_NRD;
                        end
                    end else if (i_sts.st_eq) begin
                        c.st_ld   = 1'b1;
                        c.st_code = ffra_pkg::ST_DOUBLE;
                        n_state   = S_FIN;
                    end else if (i_sts.st_gt) begin
                        priority if (i_sts.full) begin
                            c.st_ld   = 1'b1;
                            c.st_code = ffra_pkg::ST_FULL;
                            n_state   = S_FIN;
                        end else if (i_sts.new_merge) begin
                            c.we    = 1'b1;
                            c.wsel  = ffra_pkg::W_NEWM;
                            c.ftop  = ffra_pkg::FT_ADD;
                            n_state = S_FIN;
                        end else begin
                            c.ftop  = ffra_pkg::FT_ADD;
                            c.jop   = ffra_pkg::J_CNTM1;
                            n_state = S_SUR;
                        end
                    end else if (i_sts.last) begin
                        priority if (!i_sts.end_lt) begin
                            c.st_ld   = 1'b1;
                            c.st_code = ffra_pkg::ST_NOTFOUND;
                        end else if (i_sts.full) begin
                            c.st_ld   = 1'b1;
                            c.st_code = ffra_pkg::ST_FULL;
                        end else begin
                            c.we    = 1'b1;
                            c.wsel  = ffra_pkg::W_APP;
                            c.cntop = ffra_pkg::CNT_INC;
                            c.ftop  = ffra_pkg::FT_ADD;
                        end
                        n_state = S_FIN;
                    end else begin
                        c.idx_inc = 1'b1;
                        n_state   = S_RD;
                    end
                end
            end
            S_NRD: begin
                c.rd_sel = ffra_pkg::RS_IDXP1;
                n_state  = S_NEV;
            end
            S_NEV: begin
                c.we = 1'b1;
                if (i_sts.nxt_merge) begin
                    c.wsel  = ffra_pkg::W_CURM;
                    c.cntop = ffra_pkg::CNT_DEC;
                    if (i_sts.p2_lt_cnt) begin
                        c.jop   = ffra_pkg::J_IDXP2;
                        n_state = S_SDR;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    c.wsel  = ffra_pkg::W_CUR;
                    n_state = S_FIN;
                end
            end
            S_SDR: begin
                c.rd_sel = ffra_pkg::RS_J;
                n_state  = S_SDW;
            end
            S_SDW: begin
                c.we   = 1'b1;
                c.wsel = ffra_pkg::W_SHD;
                if (i_sts.j_lt_cnt) begin
                    c.jop   = ffra_pkg::J_INC;
                    n_state = S_SDR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SUR: begin
                c.rd_sel = ffra_pkg::RS_J;
                n_state  = S_SUW;
            end
            S_SUW: begin
                c.we   = 1'b1;
                c.wsel = ffra_pkg::W_SHU;
                if (i_sts.j_eq_idx) begin
                    n_state = S_INS;
                end else begin
                    c.jop   = ffra_pkg::J_DEC;
                    n_state = S_SUR;
                end
            end
            S_INS: begin
                c.we    = 1'b1;
                c.wsel  = ffra_pkg::W_NEW;
                c.cntop = ffra_pkg::CNT_INC;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    c.out_ld = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ctl       = c;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire
